FILE: design/radius_packet_parser_core_defines.svh
// Shared assertion macros for the RADIUS parser.
`ifndef RADIUS_PACKET_PARSER_CORE_DEFINES_SVH
`define RADIUS_PACKET_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpp same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpp next-cycle check failed");

`endif

FILE: design/rpp_pkg.sv
`timescale 1ns / 1ps

package rpp_pkg;

  localparam logic [15:0] MIN_PACKET = 16'd20;
  localparam logic [7:0]  ATTR_HDR   = 8'd2;
  localparam int          BYTE_SHIFT = 8;
  localparam logic [14:0] COUNT_MAX  = 15'h7FFF;
  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  localparam logic [7:0] CODE_ACCESS_REQUEST  = 8'd1;
  localparam logic [7:0] CODE_ACCT_REQUEST    = 8'd4;
  localparam logic [7:0] CODE_ACCT_RESPONSE   = 8'd5;

  typedef enum logic [2:0] {
    KIND_TOO_SHORT = 3'd0,
    KIND_HEADER    = 3'd1,
    KIND_AUTH      = 3'd2,
    KIND_ATTR      = 3'd3,
    KIND_VALUE     = 3'd4,
    KIND_STOPPED   = 3'd5,
    KIND_DONE      = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_STOP   = 3'd4,
    PH_SHORT  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] buffer_bytes;
    logic        last_byte;
  } in_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  code;
    logic [7:0]  identifier;
    logic [15:0] declared_length;
    logic        request_flag;
    logic        accounting_flag;
    logic [7:0]  attr_type;
    logic [7:0]  attr_length;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [14:0] attr_count;
    logic        end_of_run;
  } res_t;

  // Up to two results per accepted word, main result first.
  typedef struct packed {
    logic valid_main;
    logic valid_done;
    res_t main;
    res_t done;
  } push_t;

  typedef struct packed {
    logic pos_zero;
    logic in_header;
  } step_status_t;

endpackage

FILE: design/rpp_in_if.sv
`timescale 1ns / 1ps

interface rpp_in_if;
  logic         valid;
  logic         ready;
  rpp_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/rpp_out_if.sv
`timescale 1ns / 1ps

interface rpp_out_if;
  logic          valid;
  logic          ready;
  rpp_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/rpp_step.sv
`timescale 1ns / 1ps

module rpp_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  rpp_pkg::in_t          word,
  output rpp_pkg::push_t        push,
  output rpp_pkg::step_status_t status
);

  rpp_pkg::phase_t phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] region_end, region_end_next;
  logic [7:0]  held_code, held_code_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_len_hi, held_len_hi_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [7:0]  cur_len, cur_len_next;
  logic [7:0]  value_left, value_left_next;
  logic [7:0]  value_index, value_index_next;
  logic [14:0] count, count_next;

  logic [7:0]  b;
  logic [15:0] decl_len;
  logic        len_bad;

  assign b        = word.data_byte;
  assign decl_len = {held_len_hi, b};
  assign len_bad  = (b < rpp_pkg::ATTR_HDR) ||
                    (({1'b0, pos} + {9'b0, b}) > ({1'b0, region_end} + 17'd1));

  // Next state
  always_comb begin
    phase_next       = phase;
    pos_next         = (pos != rpp_pkg::POS_MAX) ? pos + 16'd1 : pos;
    region_end_next  = region_end;
    held_code_next   = held_code;
    held_id_next     = held_id;
    held_len_hi_next = held_len_hi;
    cur_type_next    = cur_type;
    cur_len_next     = cur_len;
    value_left_next  = value_left;
    value_index_next = value_index;
    count_next       = count;
    unique case (phase)
      rpp_pkg::PH_HEADER: begin
        if (pos == 16'd0 && word.buffer_bytes < rpp_pkg::MIN_PACKET) begin
          phase_next = rpp_pkg::PH_SHORT;
        end else if (pos == 16'd0) begin
          held_code_next = b;
        end else if (pos == 16'd1) begin
          held_id_next = b;
        end else if (pos == 16'd2) begin
          held_len_hi_next = b;
        end else if (pos == 16'd3) begin
          if (decl_len < rpp_pkg::MIN_PACKET || decl_len > word.buffer_bytes) begin
            region_end_next = word.buffer_bytes;
          end else begin
            region_end_next = decl_len;
          end
        end else if (pos + 16'd1 >= rpp_pkg::MIN_PACKET) begin
          phase_next = rpp_pkg::PH_TYPE;
        end
      end
      rpp_pkg::PH_TYPE: begin
        if (pos < region_end) begin
          if (pos + 16'd1 < region_end) begin
            cur_type_next = b;
            phase_next    = rpp_pkg::PH_LEN;
          end else begin
            phase_next = rpp_pkg::PH_STOP;
          end
        end
      end
      rpp_pkg::PH_LEN: begin
        cur_len_next = b;
        if (len_bad) begin
          phase_next = rpp_pkg::PH_STOP;
        end else begin
          if (count != rpp_pkg::COUNT_MAX) count_next = count + 15'd1;
          if (b > rpp_pkg::ATTR_HDR) begin
            value_left_next  = b - rpp_pkg::ATTR_HDR;
            value_index_next = 8'd0;
            phase_next       = rpp_pkg::PH_VALUE;
          end else begin
            phase_next = rpp_pkg::PH_TYPE;
          end
        end
      end
      rpp_pkg::PH_VALUE: begin
        value_index_next = value_index + 8'd1;
        if (value_left != 8'd0) value_left_next = value_left - 8'd1;
        if (value_left <= 8'd1) phase_next = rpp_pkg::PH_TYPE;
      end
      default: begin
      end
    endcase
  end

  // Results
  always_comb begin
    push = '0;
    push.main.result_kind = rpp_pkg::KIND_TOO_SHORT;
    push.done.result_kind = rpp_pkg::KIND_DONE;
    push.done.attr_count  = count_next;
    push.done.end_of_run  = 1'b1;
    push.valid_done       = take && word.last_byte && (phase_next != rpp_pkg::PH_SHORT);
    unique case (phase)
      rpp_pkg::PH_HEADER: begin
        if (pos == 16'd0 && word.buffer_bytes < rpp_pkg::MIN_PACKET) begin
          push.valid_main      = take;
          push.main.end_of_run = 1'b1;
        end else if (pos == 16'd3) begin
          push.valid_main            = take;
          push.main.result_kind      = rpp_pkg::KIND_HEADER;
          push.main.code             = held_code;
          push.main.identifier       = held_id;
          push.main.declared_length  = decl_len;
          push.main.request_flag     = (held_code == rpp_pkg::CODE_ACCESS_REQUEST) ||
                                       (held_code == rpp_pkg::CODE_ACCT_REQUEST);
          push.main.accounting_flag  = (held_code == rpp_pkg::CODE_ACCT_REQUEST) ||
                                       (held_code == rpp_pkg::CODE_ACCT_RESPONSE);
        end else if (pos > 16'd3) begin
          push.valid_main        = take;
          push.main.result_kind  = rpp_pkg::KIND_AUTH;
          push.main.payload_byte = b;
          push.main.byte_index   = 8'(pos - 16'd4);
        end
      end
      rpp_pkg::PH_LEN: begin
        push.valid_main       = take;
        push.main.result_kind = len_bad ? rpp_pkg::KIND_STOPPED : rpp_pkg::KIND_ATTR;
        push.main.attr_type   = cur_type;
        push.main.attr_length = b;
        push.main.attr_count  = count_next;
      end
      rpp_pkg::PH_VALUE: begin
        push.valid_main        = take;
        push.main.result_kind  = rpp_pkg::KIND_VALUE;
        push.main.attr_type    = cur_type;
        push.main.attr_length  = cur_len;
        push.main.attr_count   = count;
        push.main.payload_byte = b;
        push.main.byte_index   = value_index;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (take && word.last_byte)) begin
      phase       <= rpp_pkg::PH_HEADER;
      pos         <= '0;
      region_end  <= '0;
      held_code   <= '0;
      held_id     <= '0;
      held_len_hi <= '0;
      cur_type    <= '0;
      cur_len     <= '0;
      value_left  <= '0;
      value_index <= '0;
      count       <= '0;
    end else if (take) begin
      phase       <= phase_next;
      pos         <= pos_next;
      region_end  <= region_end_next;
      held_code   <= held_code_next;
      held_id     <= held_id_next;
      held_len_hi <= held_len_hi_next;
      cur_type    <= cur_type_next;
      cur_len     <= cur_len_next;
      value_left  <= value_left_next;
      value_index <= value_index_next;
      count       <= count_next;
    end
  end

  assign status.pos_zero  = (pos == 16'd0);
  assign status.in_header = (phase == rpp_pkg::PH_HEADER);

endmodule

FILE: design/rpp_res_queue.sv
`timescale 1ns / 1ps

module rpp_res_queue (
  input  logic           clk,
  input  logic           rst,
  input  rpp_pkg::push_t push,
  output logic           room,
  output logic [2:0]     fill,
  output logic           head_valid,
  output rpp_pkg::res_t  head,
  input  logic           pop
);

  rpp_pkg::res_t slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [1:0] n_push;
  logic       do_pop;
  logic       push_main_only, push_done_only;

  assign n_push         = {1'b0, push.valid_main} + {1'b0, push.valid_done};
  assign do_pop         = pop && head_valid;
  assign head_valid     = (fill != 3'd0);
  assign head           = slots[rd_ptr];
  // Leave space for two words so a final byte never overflows.
  assign room           = (fill <= 3'd2);
  assign push_main_only = push.valid_main;
  assign push_done_only = push.valid_done && !push.valid_main;

  always_ff @(posedge clk) begin
    if (push_main_only) slots[wr_ptr] <= push.main;
    if (push_done_only) slots[wr_ptr] <= push.done;
    if (push.valid_main && push.valid_done) slots[wr_ptr + 2'd1] <= push.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, n_push} - {2'b0, do_pop};
    end
  end

endmodule

FILE: design/radius_packet_parser_core.sv
// RADIUS packet parser, one packet byte per input word.
// pkt_in carries data_byte, buffer_bytes (held constant over a packet) and
// last_byte; a word moves when valid and ready are both high.
// res_out carries one result word per handshake: too_short, header,
// authenticator bytes, attribute starts, value bytes, walk stopped and done.
// Throughput: one input byte per cycle while pkt_in.ready is high. A byte
// is parsed in the cycle it is accepted; its result is registered in a
// four-entry result queue and offered on res_out behind earlier results.
// The final byte of a packet can add a second result (done) behind it.
// Bytes that give no result (header bytes 0-2, attribute type bytes, bytes
// past the region) only advance the parser.
// pkt_in.ready drops when the queue holds more than two words, so a stall
// on res_out holds every pending result and backs up the input once three
// or four results wait; nothing is dropped.
// Reset (rst, synchronous) empties the queue and puts the parser at the
// start of a packet; the last byte of every packet does the same for the
// parser.
`timescale 1ns / 1ps
`include "radius_packet_parser_core_defines.svh"

module radius_packet_parser_core (
  input logic        clk,
  input logic        rst,
  rpp_in_if.sink     pkt_in,
  rpp_out_if.source  res_out
);

  rpp_pkg::push_t        push;
  rpp_pkg::step_status_t status;
  logic                  room;
  logic [2:0]            fill;
  logic                  take;

  assign pkt_in.ready = room;
  assign take         = pkt_in.valid && room;

  rpp_step u_step (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .word   (pkt_in.payload),
    .push   (push),
    .status (status)
  );

  rpp_res_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .fill       (fill),
    .head_valid (res_out.valid),
    .head       (res_out.payload),
    .pop        (res_out.ready)
  );

  `RPP_ASSERT_NEXT(a_last_rewinds, clk, rst, take && pkt_in.payload.last_byte,
                   status.pos_zero && status.in_header)
  `RPP_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= 3'd4)
  `RPP_ASSERT_NOW(a_end_kind, clk, rst, res_out.valid && res_out.payload.end_of_run,
                  res_out.payload.result_kind == rpp_pkg::KIND_TOO_SHORT ||
                  res_out.payload.result_kind == rpp_pkg::KIND_DONE)
  `RPP_ASSERT_NOW(a_done_needs_last, clk, rst, push.valid_done,
                  take && pkt_in.payload.last_byte)

endmodule
